// File: rtl/core/rmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter package
// Shared widths, default window bound and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rmf_pkg;

    // Fixed field widths
    localparam int RMF_SAMPLE_W   = 16;
    localparam int RMF_CFG_W      = 4;

    // Default largest window built
    localparam int RMF_MAX_WINDOW = 15;

    // Sequencer states, one-hot
    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_INIT    = 11'b000_0000_0010,
        ST_RD_GONE = 11'b000_0000_0100,
        ST_RD_MID  = 11'b000_0000_1000,
        ST_DECIDE  = 11'b000_0001_0000,
        ST_SCAN    = 11'b000_0010_0000,
        ST_FT_LOW  = 11'b000_0100_0000,
        ST_FT_HIGH = 11'b000_1000_0000,
        ST_FT_VAL  = 11'b001_0000_0000,
        ST_UPDATE  = 11'b010_0000_0000,
        ST_EMIT    = 11'b100_0000_0000
    } rmf_state_t;

endpackage

// File: rtl/core/rmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/running_median_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter core
// Sliding-window median over 16-bit samples, window kept in two RAMs.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. A window_size of 0 or 1 passes the sample
// straight through. Otherwise the window length n is window_size clipped to
// MAX_WINDOW and rounded up to odd, with h = n/2. A filtered sample rescans
// none, one or both halves of the window. The rescan walks the half's slot
// list one entry a cycle through the single read port of the sample RAM. The
// first sample after reset or after a change of effective length fills the
// window first. The next sample is taken as soon as the result is placed in
// the output register.
// ----------------------------------------------------------------------------
module running_median_filter_core #(
    parameter int MAX_WINDOW = rmf_pkg::RMF_MAX_WINDOW
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample input
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rmf_pkg::RMF_SAMPLE_W-1:0] sample,
    // median output
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rmf_pkg::RMF_SAMPLE_W-1:0] median,
    // window size register write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rmf_pkg::RMF_CFG_W-1:0]    window_size
);

    import rmf_pkg::*;

    localparam int HALF_MAX = MAX_WINDOW / 2;
    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
    localparam int POS_W    = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1;
    localparam int SDEPTH   = 2 * HALF_MAX;
    localparam int SA_W     = $clog2(SDEPTH);
    localparam int EW       = ((LEN_W > RMF_CFG_W) ? LEN_W : RMF_CFG_W) + 1;

    // Control state
    rmf_state_t              state_reg, state_next;
    logic [RMF_CFG_W-1:0]    win_reg, win_next;
    logic [LEN_W-1:0]        active_reg, active_next;
    logic [SLOT_W-1:0]       rp_reg, rp_next;
    logic [SLOT_W-1:0]       med_reg, med_next;
    logic [POS_W-1:0]        lmp_reg, lmp_next;
    logic [POS_W-1:0]        hmp_reg, hmp_next;
    logic                    lstale_reg, lstale_next;
    logic                    hstale_reg, hstale_next;
    logic                    out_valid_reg, out_valid_next;

    // Working registers
    logic [RMF_SAMPLE_W-1:0] x_reg, x_next;
    logic [RMF_SAMPLE_W-1:0] res_reg, res_next;
    logic [RMF_SAMPLE_W-1:0] gone_reg, gone_next;
    logic [RMF_SAMPLE_W-1:0] ltop_reg, ltop_next;
    logic [RMF_SAMPLE_W-1:0] best_reg, best_next;
    logic [RMF_SAMPLE_W-1:0] median_reg, median_next;
    logic [SLOT_W-1:0]       lslot_reg, lslot_next;
    logic [SLOT_W-1:0]       hslot_reg, hslot_next;
    logic [LEN_W-1:0]        cnt_reg, cnt_next;
    logic                    half_reg, half_next;
    logic                    scan_hi_reg, scan_hi_next;

    // RAM ports
    logic                    ring_we;
    logic [SLOT_W-1:0]       ring_waddr, ring_raddr;
    logic [RMF_SAMPLE_W-1:0] ring_wdata, ring_rdata;
    logic                    slot_we;
    logic [SA_W-1:0]         slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]       slot_wdata, slot_rdata;

    // Helpers
    logic [EW-1:0]           req_w, clip_w, odd_w, fit_w;
    logic [LEN_W-1:0]        len_n, len_h;
    logic                    bypass;
    logic [LEN_W-1:0]        k_idx1, k_idx2, init_hi_idx;
    logic [SLOT_W-1:0]       slot_fix, rp_inc;
    logic [SA_W-1:0]         half_base;
    logic                    s2_better, scan_lo, scan_hi, out_load;

    // Sample ring and slot lists (low half at 0, high half at HALF_MAX)
    rmf_ram #(
        .WIDTH (RMF_SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    rmf_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SDEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Clip, round up to odd, pull back inside the bound
    assign req_w  = EW'(win_reg);
    assign clip_w = (req_w > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : req_w;
    assign odd_w  = clip_w | EW'(1);
    assign fit_w  = (odd_w > EW'(MAX_WINDOW)) ? (odd_w - EW'(2)) : odd_w;
    assign len_n  = LEN_W'(fit_w);
    assign len_h  = len_n >> 1;
    assign bypass = (win_reg <= RMF_CFG_W'(1));

    // Scan pipeline indexes and slot fixup
    assign k_idx1      = cnt_reg - LEN_W'(1);
    assign k_idx2      = cnt_reg - LEN_W'(2);
    assign init_hi_idx = cnt_reg - len_h - LEN_W'(1);
    assign half_base   = half_reg ? SA_W'(HALF_MAX) : '0;
    assign slot_fix    = (slot_rdata == rp_reg) ? med_reg : slot_rdata;
    assign s2_better   = half_reg ? (ring_rdata < best_reg) : (ring_rdata > best_reg);
    assign scan_lo     = (gone_reg <= ring_rdata) || lstale_reg;
    assign scan_hi     = (gone_reg >= ring_rdata) || hstale_reg;
    assign rp_inc      = ((LEN_W'(rp_reg) + LEN_W'(1)) >= len_n) ? '0 : (rp_reg + SLOT_W'(1));

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign median    = median_reg;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        win_next     = win_reg;
        active_next  = active_reg;
        rp_next      = rp_reg;
        med_next     = med_reg;
        lmp_next     = lmp_reg;
        hmp_next     = hmp_reg;
        lstale_next  = lstale_reg;
        hstale_next  = hstale_reg;
        x_next       = x_reg;
        res_next     = res_reg;
        gone_next    = gone_reg;
        ltop_next    = ltop_reg;
        best_next    = best_reg;
        lslot_next   = lslot_reg;
        hslot_next   = hslot_reg;
        cnt_next     = cnt_reg;
        half_next    = half_reg;
        scan_hi_next = scan_hi_reg;
        ring_we      = 1'b0;
        ring_waddr   = rp_reg;
        ring_wdata   = x_reg;
        ring_raddr   = rp_reg;
        slot_we      = 1'b0;
        slot_waddr   = '0;
        slot_wdata   = '0;
        slot_raddr   = '0;
        in_stall     = 1'b1;
        out_load     = 1'b0;

        // Take a register write
        if (cfg_valid && cfg_ready)
        begin
            win_next = window_size;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    x_next = sample;
                    if (bypass)
                    begin
                        res_next   = sample;
                        state_next = ST_EMIT;
                    end
                    else if (len_n != active_reg)
                    begin
                        active_next = len_n;
                        cnt_next    = '0;
                        rp_next     = '0;
                        med_next    = SLOT_W'(len_h);
                        lmp_next    = '0;
                        hmp_next    = '0;
                        lstale_next = 1'b0;
                        hstale_next = 1'b0;
                        state_next  = ST_INIT;
                    end
                    else
                    begin
                        state_next = ST_RD_GONE;
                    end
                end
            end

            ST_INIT:
            begin
                // Fill one ring entry per cycle, and its slot list entry unless it is the median slot
                ring_we    = 1'b1;
                ring_waddr = cnt_reg[SLOT_W-1:0];
                ring_wdata = x_reg;
                if (cnt_reg < len_h)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = SA_W'(POS_W'(cnt_reg));
                    slot_wdata = SLOT_W'(cnt_reg);
                end
                else if (cnt_reg > len_h)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = SA_W'(HALF_MAX) + SA_W'(POS_W'(init_hi_idx));
                    slot_wdata = SLOT_W'(cnt_reg);
                end
                if (cnt_reg == (len_n - LEN_W'(1)))
                begin
                    state_next = ST_RD_GONE;
                end
                else
                begin
                    cnt_next = cnt_reg + LEN_W'(1);
                end
            end

            ST_RD_GONE:
            begin
                ring_raddr = rp_reg;
                state_next = ST_RD_MID;
            end

            ST_RD_MID:
            begin
                ring_raddr = med_reg;
                gone_next  = ring_rdata;
                state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                // ring_rdata holds the current median value
                scan_hi_next = scan_hi;
                cnt_next     = '0;
                if (scan_lo)
                begin
                    half_next  = 1'b0;
                    state_next = ST_SCAN;
                end
                else if (scan_hi)
                begin
                    half_next  = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FT_LOW;
                end
            end

            ST_SCAN:
            begin
                // Issue slot read
                if (cnt_reg < len_h)
                begin
                    slot_raddr = half_base + SA_W'(POS_W'(cnt_reg));
                end
                // Replace the leaving slot, read its sample
                if ((cnt_reg >= LEN_W'(1)) && (cnt_reg <= len_h))
                begin
                    ring_raddr = slot_fix;
                    if (slot_rdata == rp_reg)
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = half_base + SA_W'(POS_W'(k_idx1));
                        slot_wdata = med_reg;
                    end
                end
                // Track the extreme of the half
                if (cnt_reg >= LEN_W'(2))
                begin
                    if ((cnt_reg == LEN_W'(2)) || s2_better)
                    begin
                        best_next = ring_rdata;
                        if (half_reg)
                        begin
                            hmp_next = POS_W'(k_idx2);
                        end
                        else
                        begin
                            lmp_next = POS_W'(k_idx2);
                        end
                    end
                end
                if (cnt_reg == (len_h + LEN_W'(1)))
                begin
                    if (half_reg)
                    begin
                        hstale_next = 1'b0;
                    end
                    else
                    begin
                        lstale_next = 1'b0;
                    end
                    cnt_next = '0;
                    if (!half_reg && scan_hi_reg)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FT_LOW;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + LEN_W'(1);
                end
            end

            ST_FT_LOW:
            begin
                slot_raddr = SA_W'(lmp_reg);
                state_next = ST_FT_HIGH;
            end

            ST_FT_HIGH:
            begin
                lslot_next = slot_rdata;
                ring_raddr = slot_rdata;
                slot_raddr = SA_W'(HALF_MAX) + SA_W'(hmp_reg);
                state_next = ST_FT_VAL;
            end

            ST_FT_VAL:
            begin
                hslot_next = slot_rdata;
                ltop_next  = ring_rdata;
                ring_raddr = slot_rdata;
                state_next = ST_UPDATE;
            end

            ST_UPDATE:
            begin
                // ring_rdata holds the high half minimum
                ring_we    = 1'b1;
                ring_waddr = rp_reg;
                ring_wdata = x_reg;
                rp_next    = rp_inc;
                if (x_reg < ltop_reg)
                begin
                    med_next    = lslot_reg;
                    slot_we     = 1'b1;
                    slot_waddr  = SA_W'(lmp_reg);
                    slot_wdata  = rp_reg;
                    lstale_next = 1'b1;
                    res_next    = (lslot_reg == rp_reg) ? x_reg : ltop_reg;
                end
                else if (x_reg > ring_rdata)
                begin
                    med_next    = hslot_reg;
                    slot_we     = 1'b1;
                    slot_waddr  = SA_W'(HALF_MAX) + SA_W'(hmp_reg);
                    slot_wdata  = rp_reg;
                    hstale_next = 1'b1;
                    res_next    = (hslot_reg == rp_reg) ? x_reg : ring_rdata;
                end
                else
                begin
                    med_next = rp_reg;
                    res_next = x_reg;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: load a new beat or drop a taken one
        out_valid_next = out_load || (out_valid_reg && out_stall);
        median_next    = out_load ? res_reg : median_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= '0;
            active_reg    <= '0;
            rp_reg        <= '0;
            med_reg       <= '0;
            lmp_reg       <= '0;
            hmp_reg       <= '0;
            lstale_reg    <= 1'b0;
            hstale_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            active_reg    <= active_next;
            rp_reg        <= rp_next;
            med_reg       <= med_next;
            lmp_reg       <= lmp_next;
            hmp_reg       <= hmp_next;
            lstale_reg    <= lstale_next;
            hstale_reg    <= hstale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        res_reg     <= res_next;
        gone_reg    <= gone_next;
        ltop_reg    <= ltop_next;
        best_reg    <= best_next;
        median_reg  <= median_next;
        lslot_reg   <= lslot_next;
        hslot_reg   <= hslot_next;
        cnt_reg     <= cnt_next;
        half_reg    <= half_next;
        scan_hi_reg <= scan_hi_next;
    end

    // Ring pointer stays inside the active window
    a_rp_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg != '0) |-> (LEN_W'(rp_reg) < active_reg))
        else $error("ring pointer outside active window");

    // Median slot stays inside the active window
    a_med_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg != '0) |-> (LEN_W'(med_reg) < active_reg))
        else $error("median slot outside active window");

    // A result with a free output register is presented next cycle
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && !out_valid_reg) |=>
            (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("result not presented from free output register");

endmodule
